// ----- design/assert_macros.svh -----
// Assertion macros shared by the PID step RTL.
// Depends on nothing; included by the sequencer and the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition at one edge implies a consequence at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pidc_pkg.sv -----
// Types, widths, microcode program and register indexes of the PID step block.
// Depends on nothing; used by every other file of the block but the assertion macros.
package pidc_pkg;

    localparam int GAIN_FRACTION_BITS = 12;
    localparam int GAIN_W  = 24;
    localparam int SAMPLE_W = 16;
    localparam int ERR_W   = SAMPLE_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int DT_W    = 16;
    localparam int DT_FRAC = 16;
    localparam int INT_W   = 48;
    localparam int DRIVE_W = 32;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = GAIN_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int MAG_W   = DIFF_W - 1;
    localparam int QUOT_W  = MAG_W + DT_FRAC;
    localparam int DIV_STEPS = QUOT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    localparam int PROG_LEN = 12;
    localparam int PC_W = $clog2(PROG_LEN);

    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_ZERO     = t_pc'(0);
    localparam t_pc PC_DIV_LOOP = t_pc'(6);
    localparam t_pc PC_DIV_FIN  = t_pc'(7);
    localparam t_pc PC_CLEAR    = t_pc'(11);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP = 2'd0,
        REG_KI = 2'd1,
        REG_KD = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_ERR,
        UOP_DIVINIT,
        UOP_INTEG,
        UOP_DIVSTEP,
        UOP_DIVFIN,
        UOP_FINISH,
        UOP_CLEAR
    } t_uop;

    typedef enum logic [1:0] {A_DT, A_KP, A_KI, A_KD} t_asel;
    typedef enum logic [1:0] {B_ERR, B_IHI, B_ILO, B_DERIV} t_bsel;
    typedef enum logic [1:0] {ACC_HOLD, ACC_CLEAR, ACC_ADD, ACC_ADD_SHR} t_acc;
    typedef enum logic [2:0] {J_NEXT, J_IF_CLEAR, J_IF_DT_ZERO, J_IF_DIV_BUSY, J_END} t_jmp;

    typedef struct packed {
        t_uop  op;
        t_asel asel;
        t_bsel bsel;
        t_acc  acc;
        t_jmp  jmp;
        t_pc   target;
    } t_ucode;

    typedef struct packed {
        logic   fire;
        t_ucode uc;
    } t_ctrl;

    typedef struct packed {
        logic is_clear;
        logic dt_zero;
        logic div_last;
        logic out_blocked;
    } t_stat;

    typedef struct packed {
        logic                       operation;
        logic signed [SAMPLE_W-1:0] measurement;
        logic signed [SAMPLE_W-1:0] reference;
        logic [DT_W-1:0]            elapsed_time;
        logic                       integrate_enable;
    } t_item;

    // The multiplier result of one step is registered and consumed by the next step.
    localparam t_ucode PROGRAM [PROG_LEN] = '{
        '{UOP_ERR,     A_DT, B_ERR,   ACC_CLEAR,   J_IF_CLEAR,    PC_CLEAR},
        '{UOP_DIVINIT, A_DT, B_ERR,   ACC_HOLD,    J_NEXT,        PC_ZERO},
        '{UOP_INTEG,   A_KP, B_ERR,   ACC_HOLD,    J_NEXT,        PC_ZERO},
        '{UOP_NOP,     A_KI, B_IHI,   ACC_ADD,     J_NEXT,        PC_ZERO},
        '{UOP_NOP,     A_KI, B_ILO,   ACC_ADD,     J_NEXT,        PC_ZERO},
        '{UOP_NOP,     A_DT, B_ERR,   ACC_ADD_SHR, J_IF_DT_ZERO,  PC_DIV_FIN},
        '{UOP_DIVSTEP, A_DT, B_ERR,   ACC_HOLD,    J_IF_DIV_BUSY, PC_DIV_LOOP},
        '{UOP_DIVFIN,  A_DT, B_ERR,   ACC_HOLD,    J_NEXT,        PC_ZERO},
        '{UOP_NOP,     A_KD, B_DERIV, ACC_HOLD,    J_NEXT,        PC_ZERO},
        '{UOP_NOP,     A_DT, B_ERR,   ACC_ADD,     J_NEXT,        PC_ZERO},
        '{UOP_FINISH,  A_DT, B_ERR,   ACC_HOLD,    J_END,         PC_ZERO},
        '{UOP_CLEAR,   A_DT, B_ERR,   ACC_HOLD,    J_END,         PC_ZERO}
    };

endpackage

// ----- design/pidc_if.sv -----
// Request channels of the PID step block: input, result and register write.
// Depends on pidc_pkg for the payload widths.
interface pidc_in_if import pidc_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic signed [SAMPLE_W-1:0] measurement;
    logic signed [SAMPLE_W-1:0] reference;
    logic [DT_W-1:0]            elapsed_time;
    logic                       integrate_enable;

    modport source (output valid, operation, measurement, reference, elapsed_time,
                    integrate_enable, input ready);
    modport sink (input valid, operation, measurement, reference, elapsed_time,
                  integrate_enable, output ready);
endinterface

interface pidc_out_if import pidc_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive_value;
    logic                      saturated;

    modport source (output valid, drive_value, saturated, input ready);
    modport sink (input valid, drive_value, saturated, output ready);
endinterface

interface pidc_cfg_if import pidc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/pidc_div.sv -----
// Radix-2 restoring divider, one quotient bit per step, for the derivative.
// Depends on pidc_pkg for widths.
module pidc_div import pidc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_init,
    input  logic              i_step,
    input  logic [MAG_W-1:0]  i_dividend_mag,
    input  logic [DT_W-1:0]   i_divisor,
    output logic [QUOT_W-1:0] o_quot,
    output logic              o_last
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_CNT_W-1:0] n_cnt;
    logic [QUOT_W-1:0]    r_nq;
    logic [QUOT_W-1:0]    n_nq;
    logic [DT_W-1:0]      r_rem;
    logic [DT_W-1:0]      n_rem;
    logic [DT_W:0]        w_trial;
    logic [DT_W:0]        w_diff;

    always_comb begin
        w_trial = {r_rem, r_nq[QUOT_W-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        n_cnt = r_cnt;
        n_nq  = r_nq;
        n_rem = r_rem;
        if (i_init) begin
            n_cnt = DIV_CNT_W'(DIV_STEPS - 1);
            n_nq  = {i_dividend_mag, {DT_FRAC{1'b0}}};
            n_rem = '0;
        end else if (i_step) begin
            if (r_cnt != '0) begin
                n_cnt = r_cnt - 1'b1;
            end
            if (w_trial >= {1'b0, i_divisor}) begin
                n_rem = w_diff[DT_W-1:0];
                n_nq  = {r_nq[QUOT_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DT_W-1:0];
                n_nq  = {r_nq[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nq  <= n_nq;
        r_rem <= n_rem;
    end

    assign o_quot = r_nq;
    assign o_last = (r_cnt == '0);

endmodule

// ----- design/pidc_seq.sv -----
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on pidc_pkg for the program and the control and status types.
`include "assert_macros.svh"

module pidc_seq import pidc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_busy
);

    t_pc    r_pc;
    t_pc    n_pc;
    logic   r_busy;
    logic   n_busy;
    t_ucode w_uc;
    logic   w_emit;
    logic   w_fire;
    t_pc    w_seq;

    always_comb begin
        w_uc   = PROGRAM[r_pc];
        w_emit = (w_uc.op == UOP_FINISH) || (w_uc.op == UOP_CLEAR);
        w_fire = r_busy && !(w_emit && i_stat.out_blocked);
        w_seq  = r_pc + 1'b1;
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_start) begin
            n_pc   = PC_ZERO;
            n_busy = 1'b1;
        end else if (w_fire) begin
            unique case (w_uc.jmp)
                J_NEXT:        n_pc = w_seq;
                J_IF_CLEAR:    n_pc = i_stat.is_clear ? w_uc.target : w_seq;
                J_IF_DT_ZERO:  n_pc = i_stat.dt_zero ? w_uc.target : w_seq;
                J_IF_DIV_BUSY: n_pc = i_stat.div_last ? w_seq : w_uc.target;
                J_END:         n_busy = 1'b0;
                default:       n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= PC_ZERO;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_ctrl.fire = w_fire;
    assign o_ctrl.uc   = w_uc;
    assign o_busy      = r_busy;

    `ASSERT_ALWAYS(a_pc_in_program, i_clk, i_rst_n, !r_busy || (r_pc < t_pc'(PROG_LEN)), "step counter left the program")
    `ASSERT_NEXT(a_end_goes_idle, i_clk, i_rst_n, w_fire && (w_uc.jmp == J_END), !r_busy, "sequencer still busy after its last step")

endmodule

// ----- design/pidc_dp.sv -----
// Datapath of the PID step: gains, stored error and integral, shared multiplier,
// accumulator, divider and result register. Depends on pidc_pkg and pidc_div.
`include "assert_macros.svh"

module pidc_dp import pidc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  t_item                     i_item,
    input  t_ctrl                     i_ctrl,
    output t_stat                     o_stat,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [GAIN_W-1:0]         i_cfg_data,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic signed [DRIVE_W-1:0] o_drive,
    output logic                      o_sat
);

    logic                       r_op;
    logic signed [SAMPLE_W-1:0] r_meas;
    logic signed [SAMPLE_W-1:0] r_ref;
    logic [DT_W-1:0]            r_dt;
    logic                       r_ien;
    logic signed [GAIN_W-1:0]   r_kp;
    logic signed [GAIN_W-1:0]   r_ki;
    logic signed [GAIN_W-1:0]   r_kd;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [ERR_W-1:0]    r_prev;
    logic signed [INT_W-1:0]    r_int;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [DRIVE_W-1:0]  r_deriv;
    logic                       r_clip;
    logic                       r_out_valid;
    logic signed [DRIVE_W-1:0]  r_drive;
    logic                       r_sat;

    logic signed [ERR_W-1:0]    w_err;
    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [GAIN_W-1:0]   w_a;
    logic signed [MUL_B_W-1:0]  w_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [INT_W:0]      w_isum;
    logic signed [INT_W-1:0]    w_int_sat;
    logic [MAG_W-1:0]           w_mag;
    logic [QUOT_W-1:0]          w_quot;
    logic                       w_div_last;
    logic signed [QUOT_W:0]     w_qs;
    logic                       w_q_ovf;
    logic signed [DRIVE_W-1:0]  w_q_sat;
    logic signed [ACC_W-1:0]    w_sh;
    logic                       w_d_ovf;
    logic signed [DRIVE_W-1:0]  w_d_sat;
    logic                       w_div_init;
    logic                       w_div_step;
    logic                       w_emit;

    always_comb begin
        w_err  = {r_ref[SAMPLE_W-1], r_ref} - {r_meas[SAMPLE_W-1], r_meas};
        w_diff = {w_err[ERR_W-1], w_err} - {r_prev[ERR_W-1], r_prev};

        unique case (i_ctrl.uc.asel)
            A_DT:    w_a = {{(GAIN_W-DT_W){1'b0}}, r_dt};
            A_KP:    w_a = r_kp;
            A_KI:    w_a = r_ki;
            A_KD:    w_a = r_kd;
            default: w_a = r_kp;
        endcase
        unique case (i_ctrl.uc.bsel)
            B_ERR:   w_b = MUL_B_W'(r_err);
            B_IHI:   w_b = r_int[INT_W-1:DT_FRAC];
            B_ILO:   w_b = {{(MUL_B_W-DT_FRAC){1'b0}}, r_int[DT_FRAC-1:0]};
            B_DERIV: w_b = r_deriv;
            default: w_b = MUL_B_W'(r_err);
        endcase
        w_prod = w_a * w_b;

        w_isum = (INT_W+1)'(r_int) + (INT_W+1)'(r_prod);
        if (w_isum[INT_W] != w_isum[INT_W-1]) begin
            w_int_sat = {w_isum[INT_W], {(INT_W-1){~w_isum[INT_W]}}};
        end else begin
            w_int_sat = w_isum[INT_W-1:0];
        end

        w_mag = r_diff[DIFF_W-1] ? MAG_W'(-r_diff) : r_diff[MAG_W-1:0];

        w_qs    = r_diff[DIFF_W-1] ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
        w_q_ovf = !((&w_qs[QUOT_W:DRIVE_W-1]) || !(|w_qs[QUOT_W:DRIVE_W-1]));
        w_q_sat = {w_qs[QUOT_W], {(DRIVE_W-1){~w_qs[QUOT_W]}}};

        w_sh    = r_acc >>> GAIN_FRACTION_BITS;
        w_d_ovf = !((&w_sh[ACC_W-1:DRIVE_W-1]) || !(|w_sh[ACC_W-1:DRIVE_W-1]));
        w_d_sat = {w_sh[ACC_W-1], {(DRIVE_W-1){~w_sh[ACC_W-1]}}};

        w_div_init = i_ctrl.fire && (i_ctrl.uc.op == UOP_DIVINIT);
        w_div_step = i_ctrl.fire && (i_ctrl.uc.op == UOP_DIVSTEP);
        w_emit = i_ctrl.fire && ((i_ctrl.uc.op == UOP_FINISH) || (i_ctrl.uc.op == UOP_CLEAR));
    end

    pidc_div u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_init         (w_div_init),
        .i_step         (w_div_step),
        .i_dividend_mag (w_mag),
        .i_divisor      (r_dt),
        .o_quot         (w_quot),
        .o_last         (w_div_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_prev      <= '0;
            r_int       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KP:  r_kp <= i_cfg_data;
                    REG_KI:  r_ki <= i_cfg_data;
                    REG_KD:  r_kd <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_ctrl.fire) begin
                unique case (i_ctrl.uc.op)
                    UOP_ERR:   r_prev <= w_err;
                    UOP_INTEG: begin
                        if (r_ien) begin
                            r_int <= w_int_sat;
                        end
                    end
                    UOP_CLEAR: begin
                        r_prev <= '0;
                        r_int  <= '0;
                    end
                    default: ;
                endcase
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_item.operation;
            r_meas <= i_item.measurement;
            r_ref  <= i_item.reference;
            r_dt   <= i_item.elapsed_time;
            r_ien  <= i_item.integrate_enable;
        end
        if (i_ctrl.fire) begin
            r_prod <= w_prod;
            unique case (i_ctrl.uc.acc)
                ACC_HOLD:    r_acc <= r_acc;
                ACC_CLEAR:   r_acc <= '0;
                ACC_ADD:     r_acc <= r_acc + ACC_W'(r_prod);
                ACC_ADD_SHR: r_acc <= r_acc + ACC_W'(r_prod >>> DT_FRAC);
                default:     r_acc <= r_acc;
            endcase
            unique case (i_ctrl.uc.op)
                UOP_ERR: begin
                    r_err  <= w_err;
                    r_diff <= w_diff;
                end
                UOP_DIVFIN: begin
                    if (r_dt == '0) begin
                        r_deriv <= '0;
                        r_clip  <= 1'b0;
                    end else begin
                        r_deriv <= w_q_ovf ? w_q_sat : w_qs[DRIVE_W-1:0];
                        r_clip  <= w_q_ovf;
                    end
                end
                UOP_FINISH: begin
                    r_drive <= w_d_ovf ? w_d_sat : w_sh[DRIVE_W-1:0];
                    r_sat   <= r_clip | w_d_ovf;
                end
                UOP_CLEAR: begin
                    r_drive <= '0;
                    r_sat   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.is_clear    = r_op;
    assign o_stat.dt_zero     = (r_dt == '0);
    assign o_stat.div_last    = w_div_last;
    assign o_stat.out_blocked = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_drive            = r_drive;
    assign o_sat              = r_sat;

    `ASSERT_ALWAYS(a_no_result_overwrite, i_clk, i_rst_n, !(w_emit && r_out_valid && !i_out_ready), "result written over one not yet taken")
    `ASSERT_NEXT(a_integral_holds, i_clk, i_rst_n, !i_ctrl.fire, $stable(r_int), "integral changed outside a program step")

endmodule

// ----- design/pid_controller_step.sv -----
// PID step: a control request runs the microcode program and then gives its result; the divider
// is skipped when elapsed time is zero and a clear goes straight to its result, else the divider
// runs its 33 one-bit steps for the derivative. One request is taken at a time, and the next is
// accepted in the cycle after the last step, even while the previous result still waits in the output register.
// Synchronous active-low reset clears gains, stored error, integral and the sequencer.
// Depends on pidc_pkg, the channel interfaces, pidc_seq and pidc_dp.
module pid_controller_step import pidc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pidc_in_if.sink    i_in,
    pidc_out_if.source o_out,
    pidc_cfg_if.sink   i_cfg
);

    t_ctrl w_ctrl;
    t_stat w_stat;
    logic  w_busy;
    logic  w_start;
    t_item w_item;

    assign i_in.ready  = !w_busy;
    assign w_start     = i_in.valid && !w_busy;
    assign i_cfg.ready = 1'b1;

    assign w_item.operation        = i_in.operation;
    assign w_item.measurement      = i_in.measurement;
    assign w_item.reference        = i_in.reference;
    assign w_item.elapsed_time     = i_in.elapsed_time;
    assign w_item.integrate_enable = i_in.integrate_enable;

    pidc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (w_busy)
    );

    pidc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (w_item),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_drive     (o_out.drive_value),
        .o_sat       (o_out.saturated)
    );

endmodule
